[hw/rtl/keyed_byte_unmask_rle_decoder_top_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the keyed byte unmask run-length decoder
// Shared concurrent checks, clocked on i_clk and off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEYED_BYTE_UNMASK_RLE_DECODER_TOP_DEFINES_SVH
`define KEYED_BYTE_UNMASK_RLE_DECODER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KBU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KBU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/kbu_pkg.sv]
// ---------------------------------------------------------------------------
// kbu_pkg
// Types and constants shared by the keyed byte unmask run-length decoder.
// ---------------------------------------------------------------------------
package kbu_pkg;

    localparam int KEY_BYTES_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 3;

    localparam logic [3:0] KEY_MASK_RST = 4'hF;
    localparam logic [7:0] RUN_FLAG     = 8'h80;
    localparam logic [7:0] LEN_MASK     = 8'h7F;
    localparam logic [7:0] BYTE_MASK    = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW       = 3'd0,
        CFG_KEY_HIGH      = 3'd1,
        CFG_KEY_MASK      = 3'd2,
        CFG_SOURCE_LENGTH = 3'd3,
        CFG_OUTPUT_LIMIT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_RUN     = 2'd1,
        MODE_LITERAL = 2'd2
    } t_mode;

    typedef struct packed {
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [3:0]  key_mask;
        logic [31:0] source_length;
        logic [31:0] output_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_value;
        logic [6:0] repeat_count;
    } t_result;

endpackage

[hw/rtl/kbu_if.sv]
// ---------------------------------------------------------------------------
// kbu_if
// Valid/ready channels of the decoder: source bytes, results and config.
// ---------------------------------------------------------------------------
interface kbu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       first_of_stream;

    modport source (output valid, output src_byte, output first_of_stream, input ready);
    modport sink   (input valid, input src_byte, input first_of_stream, output ready);
endinterface

interface kbu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;
    logic [6:0] repeat_count;

    modport source (output valid, output out_value, output repeat_count, input ready);
    modport sink   (input valid, input out_value, input repeat_count, output ready);
endinterface

interface kbu_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kbu_pkg::CFG_IDX_W-1:0]  addr;
    logic [63:0]                    data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[hw/rtl/kbu_queue.sv]
// ---------------------------------------------------------------------------
// kbu_queue
// Short result queue between the decode front and the output channel.
// ---------------------------------------------------------------------------
`include "keyed_byte_unmask_rle_decoder_top_defines.svh"

module kbu_queue #(
    parameter int DEPTH = kbu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kbu_pkg::t_result  i_data,
    output logic              o_full,
    kbu_out_if.source         o_res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kbu_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign pop                = o_res.valid && o_res.ready;
    assign o_full             = (r_count == CNT_W'(DEPTH));
    assign o_res.valid        = (r_count != '0);
    assign o_res.out_value    = r_mem[r_rptr].out_value;
    assign o_res.repeat_count = r_mem[r_rptr].repeat_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        case ({i_push, pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `KBU_ASSERT_NOW(a_no_push_full, i_push, r_count != CNT_W'(DEPTH), "push into full queue")
    `KBU_ASSERT_NEXT(a_count_up, i_push && !pop, r_count == $past(r_count) + CNT_W'(1), "count did not advance")

endmodule

[hw/rtl/kbu_front.sv]
// ---------------------------------------------------------------------------
// kbu_front
// Unmasks each source byte and runs the run-length decoder state; one word
// is classified per cycle while the queue has room; any result is queued.
// ---------------------------------------------------------------------------
`include "keyed_byte_unmask_rle_decoder_top_defines.svh"

module kbu_front #(
    parameter int KEY_BYTES = kbu_pkg::KEY_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kbu_in_if.sink            i_src,
    input  kbu_pkg::t_cfg     i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output kbu_pkg::t_result  o_res
);

    logic [31:0]         r_counter, n_counter;
    logic [7:0]          r_fb, n_fb;
    kbu_pkg::t_mode      r_mode, n_mode;
    logic [6:0]          r_pending, n_pending;
    logic [31:0]         r_taken, n_taken;
    logic [31:0]         r_written, n_written;
    logic                r_halted, n_halted;

    logic                accept;
    logic                first;
    logic [127:0]        key;
    logic [31:0]         e_counter;
    logic [7:0]          e_fb;
    kbu_pkg::t_mode      e_mode;
    logic [6:0]          e_pending;
    logic [31:0]         e_taken;
    logic [31:0]         e_written;
    logic                e_halted;
    logic [7:0]          k1, k2, t, y, m, d, c;
    logic [31:0]         taken_inc, remaining, room;
    logic [6:0]          run_len;

    function automatic logic [7:0] key_byte(input logic [127:0] kv, input logic [3:0] idx);
        logic [7:0] b;
        b = kv[{idx, 3'b000} +: 8];
        if ({1'b0, idx} >= 5'(KEY_BYTES)) begin
            b = 8'h00;
        end
        return b;
    endfunction

    assign accept      = i_src.valid && i_src.ready;
    assign i_src.ready = !i_full;
    assign first       = i_src.first_of_stream;
    assign key         = {i_cfg.key_high, i_cfg.key_low};

    // Stream start overrides the stored state before the word is used.
    always_comb begin
        e_counter = first ? '0 : r_counter;
        e_fb      = first ? key_byte(key, 4'd0) : r_fb;
        e_mode    = first ? kbu_pkg::MODE_HEADER : r_mode;
        e_pending = first ? '0 : r_pending;
        e_taken   = first ? '0 : r_taken;
        e_written = first ? '0 : r_written;
        e_halted  = first ? 1'b0 : r_halted;
    end

    // Unmask
    always_comb begin
        k1 = key_byte(key, e_counter[3:0] & i_cfg.key_mask);
        k2 = key_byte(key, e_counter[6:3] & i_cfg.key_mask);
        t  = e_counter[7:0] ^ e_counter[15:8];
        y  = {k1[6:0], k2[7]} ^ t;
        m  = y ^ {4'h0, y[7:4]};
        d  = (i_src.src_byte ^ m) - (e_fb ^ k1);
        c  = {d[2:0], d[7:3]};
    end

    assign taken_inc = e_taken + 32'd1;
    assign remaining = i_cfg.source_length - taken_inc;
    assign room      = i_cfg.output_limit - e_written;
    assign run_len   = (room < {25'd0, e_pending}) ? room[6:0] : e_pending;

    always_comb begin
        n_counter = e_counter;
        n_fb      = e_fb;
        n_mode    = e_mode;
        n_pending = e_pending;
        n_taken   = e_taken;
        n_written = e_written;
        n_halted  = e_halted;
        o_push    = 1'b0;
        o_res     = '{out_value: c, repeat_count: 7'd1};
        if (e_halted || e_taken >= i_cfg.source_length) begin
            // drop: stream exhausted or halted
        end else if (e_written >= i_cfg.output_limit) begin
            n_halted = 1'b1;
        end else begin
            n_counter = e_counter + 32'd1;
            n_fb      = (c + k2) ^ {1'b0, e_fb[7:1]};
            n_taken   = taken_inc;
            case (e_mode)
                kbu_pkg::MODE_LITERAL: begin
                    o_push    = 1'b1;
                    n_written = e_written + 32'd1;
                    n_pending = e_pending - 7'd1;
                    if (e_pending == 7'd1) begin
                        n_mode = kbu_pkg::MODE_HEADER;
                    end
                    if (e_written + 32'd1 >= i_cfg.output_limit) begin
                        n_halted = 1'b1;
                    end
                end
                kbu_pkg::MODE_RUN: begin
                    n_mode = kbu_pkg::MODE_HEADER;
                    if (run_len != 7'd0) begin
                        o_push             = 1'b1;
                        o_res.repeat_count = run_len;
                        n_written          = e_written + {25'd0, run_len};
                        if (e_written + {25'd0, run_len} >= i_cfg.output_limit) begin
                            n_halted = 1'b1;
                        end
                    end
                end
                default: begin
                    n_mode = kbu_pkg::MODE_HEADER;
                    if ((c & kbu_pkg::RUN_FLAG) != 8'h00) begin
                        // run header needs a value word after it
                        if (taken_inc >= i_cfg.source_length) begin
                            n_halted = 1'b1;
                        end else begin
                            n_mode    = kbu_pkg::MODE_RUN;
                            n_pending = 7'(c & kbu_pkg::LEN_MASK);
                        end
                    end else if ({24'd0, c} > remaining) begin
                        n_halted = 1'b1;
                    end else if (c != 8'h00) begin
                        n_mode    = kbu_pkg::MODE_LITERAL;
                        n_pending = c[6:0];
                    end
                end
            endcase
        end
        if (!accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_fb      <= '0;
            r_mode    <= kbu_pkg::MODE_HEADER;
            r_pending <= '0;
            r_taken   <= '0;
            r_written <= '0;
            r_halted  <= 1'b0;
        end else if (accept) begin
            r_counter <= n_counter;
            r_fb      <= n_fb;
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_taken   <= n_taken;
            r_written <= n_written;
            r_halted  <= n_halted;
        end
    end

    `KBU_ASSERT_NOW(a_count_nonzero, o_push, o_res.repeat_count != 7'd0, "zero repeat count pushed")
    `KBU_ASSERT_NOW(a_literal_len, r_mode == kbu_pkg::MODE_LITERAL, r_pending != 7'd0, "literal run with no length")
    `KBU_ASSERT_NOW(a_halt_silent, accept && !first && r_halted, !o_push, "result while halted")

endmodule

[hw/rtl/keyed_byte_unmask_rle_decoder_top.sv]
// ---------------------------------------------------------------------------
// keyed_byte_unmask_rle_decoder_top
// Keyed byte unmasker feeding a run-length decoder, with config registers.
// ---------------------------------------------------------------------------
// One source word is taken every cycle while the queue is not full. Its
// unmasking and decoding settle in that cycle in the front, whose byte-wide
// feedback state and decoder mode are registered there; any result is
// registered in a result queue of QUEUE_DEPTH entries and offered from
// there on the output channel. Input ready drops only while the queue is
// full, i.e. while the output side stalls. Each word gives at most one
// result: a byte and how many times to write it. Config writes are taken
// in every cycle and take effect from the next cycle; a key change reaches
// the feedback seed at the next word flagged first_of_stream.

module keyed_byte_unmask_rle_decoder_top #(
    parameter int KEY_BYTES   = kbu_pkg::KEY_BYTES_DEF,
    parameter int QUEUE_DEPTH = kbu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kbu_in_if.sink     i_src,
    kbu_cfg_if.sink    i_cfg,
    kbu_out_if.source  o_res
);

    kbu_pkg::t_cfg     r_cfg;
    kbu_pkg::t_result  res;
    logic              push;
    logic              full;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_low       <= '0;
            r_cfg.key_high      <= '0;
            r_cfg.key_mask      <= kbu_pkg::KEY_MASK_RST;
            r_cfg.source_length <= '0;
            r_cfg.output_limit  <= '0;
        end else if (i_cfg.valid) begin
            case (kbu_pkg::t_cfg_idx'(i_cfg.addr))
                kbu_pkg::CFG_KEY_LOW:       r_cfg.key_low       <= i_cfg.data;
                kbu_pkg::CFG_KEY_HIGH:      r_cfg.key_high      <= i_cfg.data;
                kbu_pkg::CFG_KEY_MASK:      r_cfg.key_mask      <= i_cfg.data[3:0];
                kbu_pkg::CFG_SOURCE_LENGTH: r_cfg.source_length <= i_cfg.data[31:0];
                kbu_pkg::CFG_OUTPUT_LIMIT:  r_cfg.output_limit  <= i_cfg.data[31:0];
                default: begin
                    // unmapped index: drop the word
                end
            endcase
        end
    end

    kbu_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (i_src),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_res   (res)
    );

    kbu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_full  (full),
        .o_res   (o_res)
    );

endmodule
